// File: hw/rtl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared constants and types for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrp_pkg;

    // default geometry
    localparam int FRAMES_DEF    = 512;
    localparam int PAGE_BITS_DEF = 20;

    // frame limit register
    localparam int CFG_W     = 10;
    localparam int CFG_RESET = 512;

    // running totals
    localparam int CNT_W = 32;

    // control part of a transaction walking down the cell chain
    typedef struct packed {
        logic valid;   // slot carries a transaction
        logic done;    // lookup finished upstream, just travel to the end
        logic hit;     // page found resident
        logic victim;  // carry holds an evicted page
    } lrp_ctl_t;

endpackage

// File: hw/rtl/lrp_if.sv
// ----------------------------------------------------------------------------
// lrp_req_if / lrp_rsp_if
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface lrp_req_if #(
    parameter int PAGE_BITS = lrp_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface lrp_rsp_if #(
    parameter int PAGE_BITS = lrp_pkg::PAGE_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       victim_valid;
    logic [PAGE_BITS-1:0]       victim_page;
    logic [lrp_pkg::CNT_W-1:0]  hit_total;
    logic [lrp_pkg::CNT_W-1:0]  miss_total;

    modport source (output valid, output hit, output victim_valid, output victim_page,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input victim_valid, input victim_page,
                    input hit_total, input miss_total, output ready);
endinterface

// File: hw/rtl/lrp_cell.sv
// ----------------------------------------------------------------------------
// lrp_cell
// One recency position of the LRU stack: holds a page, swaps with the carry.
// ----------------------------------------------------------------------------
module lrp_cell #(
    parameter int FRAMES    = lrp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrp_pkg::PAGE_BITS_DEF,
    parameter int IDX       = 0,
    localparam int LIM_W    = $clog2(FRAMES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [LIM_W-1:0]     limit,
    input  lrp_pkg::lrp_ctl_t    ctl_in,
    input  logic [PAGE_BITS-1:0] ref_in,
    input  logic [PAGE_BITS-1:0] carry_in,
    output lrp_pkg::lrp_ctl_t    ctl_out,
    output logic [PAGE_BITS-1:0] ref_out,
    output logic [PAGE_BITS-1:0] carry_out
);

    logic                 ent_valid_reg;
    logic                 ent_valid_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    lrp_pkg::lrp_ctl_t    ctl_reg;
    lrp_pkg::lrp_ctl_t    ctl_next;
    logic [PAGE_BITS-1:0] ref_reg;
    logic [PAGE_BITS-1:0] carry_reg;
    logic [PAGE_BITS-1:0] carry_next;
    logic                 active;
    logic                 match;
    logic                 in_limit;

    assign active   = ctl_in.valid && !ctl_in.done;
    assign match    = ent_valid_reg && (page_reg == ref_in);
    assign in_limit = LIM_W'(IDX) < limit;

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        page_next      = page_reg;
        ctl_next       = ctl_in;
        carry_next     = carry_in;
        if (active)
        begin
            if (ent_valid_reg)
            begin
                // take the more recent page, pass ours down unless it is the one referenced
                page_next = carry_in;
                if (match)
                begin
                    ctl_next.done = 1'b1;
                    ctl_next.hit  = 1'b1;
                end
                else
                begin
                    carry_next = page_reg;
                end
            end
            else if (in_limit)
            begin
                // first free position and still room: grow the set
                page_next      = carry_in;
                ent_valid_next = 1'b1;
                ctl_next.done  = 1'b1;
            end
            else
            begin
                // set is full, carry is the least recent page
                ctl_next.done   = 1'b1;
                ctl_next.victim = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            ctl_reg       <= '0;
        end
        else if (advance)
        begin
            ent_valid_reg <= ent_valid_next;
            ctl_reg       <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            page_reg  <= page_next;
            ref_reg   <= ref_in;
            carry_reg <= carry_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign ref_out   = ref_reg;
    assign carry_out = carry_reg;

endmodule

// File: hw/rtl/lru_page_replacement_top.sv
// the result passes through the FRAMES recency cells and then the result register
// throughput: one transaction per cycle while rsp is taken; each reference walks
//   the chain of FRAMES recency cells, one cell per cycle, behind the previous one
// backpressure on rsp freezes the whole chain and drops req.ready the same cycle
// reset (async, active low): resident set empty, totals zero, frame limit 512
//   clamped to FRAMES; no clearing pass is needed
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// Fully associative LRU page tracker built as a systolic recency stack.
// ----------------------------------------------------------------------------
module lru_page_replacement_top #(
    parameter int FRAMES    = lrp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrp_pkg::PAGE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lrp_pkg::CFG_W-1:0] cfg_wdata,
    lrp_req_if.sink                   req,
    lrp_rsp_if.source                 rsp
);

    localparam int LIM_W       = $clog2(FRAMES + 1);
    localparam int RESET_LIMIT = (lrp_pkg::CFG_RESET > FRAMES) ? FRAMES : lrp_pkg::CFG_RESET;
    localparam int CNT_W       = lrp_pkg::CNT_W;

    // ------------------------------------------------------------------
    // frame limit: zero reads as one, values past capacity clamp to FRAMES
    // ------------------------------------------------------------------
    logic [LIM_W-1:0] limit_reg;
    logic [LIM_W-1:0] limit_next;
    logic [31:0]      cfg_wide;

    assign cfg_wide = 32'(cfg_wdata);

    always_comb
    begin
        priority if (cfg_wide == 32'd0)
            limit_next = LIM_W'(1);
        else if (cfg_wide > 32'(FRAMES))
            limit_next = LIM_W'(FRAMES);
        else
            limit_next = cfg_wide[LIM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIM_W'(RESET_LIMIT);
        else if (cfg_we)
            limit_reg <= limit_next;
    end

    // ------------------------------------------------------------------
    // global stall: the chain moves only when the result register can load
    // ------------------------------------------------------------------
    logic rsp_valid_reg;
    logic advance;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = advance;

    // ------------------------------------------------------------------
    // cell chain; position 0 is the most recent page
    // the reference enters cell 0 as its own carry, so a hit at the head
    // simply rewrites the same page
    // ------------------------------------------------------------------
    lrp_pkg::lrp_ctl_t    ctl_chain   [FRAMES+1];
    logic [PAGE_BITS-1:0] ref_chain   [FRAMES+1];
    logic [PAGE_BITS-1:0] carry_chain [FRAMES+1];

    always_comb
    begin
        ctl_chain[0]        = '0;
        ctl_chain[0].valid  = req.valid;
        ref_chain[0]        = req.page_number;
        carry_chain[0]      = req.page_number;
    end

    for (genvar k = 0; k < FRAMES; k++)
    begin : g_cell
        lrp_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .limit     (limit_reg),
            .ctl_in    (ctl_chain[k]),
            .ref_in    (ref_chain[k]),
            .carry_in  (carry_chain[k]),
            .ctl_out   (ctl_chain[k+1]),
            .ref_out   (ref_chain[k+1]),
            .carry_out (carry_chain[k+1])
        );
    end

    // ------------------------------------------------------------------
    // chain exit: a transaction still searching after the last cell met a
    // completely full stack, so the carry is the least recent page
    // ------------------------------------------------------------------
    lrp_pkg::lrp_ctl_t    tail;
    logic                 tail_victim;
    logic [PAGE_BITS-1:0] tail_victim_page;

    assign tail             = ctl_chain[FRAMES];
    assign tail_victim      = tail.victim || !tail.done;
    assign tail_victim_page = tail_victim ? carry_chain[FRAMES] : '0;

    // saturating running totals
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_next;

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (tail.valid)
        begin
            if (tail.hit)
            begin
                if (hit_cnt_reg != '1)
                    hit_cnt_next = hit_cnt_reg + CNT_W'(1);
            end
            else
            begin
                if (miss_cnt_reg != '1)
                    miss_cnt_next = miss_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            rsp_valid_reg <= tail.valid;
        end
    end

    // result register
    logic                 rsp_hit_reg;
    logic                 rsp_victim_valid_reg;
    logic [PAGE_BITS-1:0] rsp_victim_page_reg;
    logic [CNT_W-1:0]     rsp_hit_total_reg;
    logic [CNT_W-1:0]     rsp_miss_total_reg;

    always_ff @(posedge clk)
    begin
        if (advance && tail.valid)
        begin
            rsp_hit_reg          <= tail.hit;
            rsp_victim_valid_reg <= tail_victim && !tail.hit;
            rsp_victim_page_reg  <= tail.hit ? '0 : tail_victim_page;
            rsp_hit_total_reg    <= hit_cnt_next;
            rsp_miss_total_reg   <= miss_cnt_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit          = rsp_hit_reg;
    assign rsp.victim_valid = rsp_victim_valid_reg;
    assign rsp.victim_page  = rsp_victim_page_reg;
    assign rsp.hit_total    = rsp_hit_total_reg;
    assign rsp.miss_total   = rsp_miss_total_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a hit always ends the search
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid && tail.hit |-> tail.done && !tail.victim)
        else $error("hit transaction left the chain unfinished or with a victim");

    // a stalled chain keeps its tail transaction
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(tail) && $stable(carry_chain[FRAMES]))
        else $error("chain moved while the result register was blocked");

    // miss total steps by one on each unsaturated miss
    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tail.valid && !tail.hit && (miss_cnt_reg != '1)
        |=> miss_cnt_reg == $past(miss_cnt_reg) + CNT_W'(1))
        else $error("miss total did not advance on a miss");

    // hit total never changes without a hit leaving the chain
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && tail.valid && tail.hit) |=> $stable(hit_cnt_reg))
        else $error("hit total changed without a hit");

endmodule

// File: verif/lru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_checker
// Watches the reference and result channels and keeps its own LRU recency
// stack. Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lrp_pkg::CFG_W-1:0] cfg_wdata,
    lrp_req_if                        req,
    lrp_rsp_if                        rsp,
    output int                        pending,
    output int                        fail_count,
    output int                        hit_seen,
    output int                        victim_seen
);

    localparam int PW         = lrp_pkg::PAGE_BITS_DEF;
    localparam int CFG_W      = lrp_pkg::CFG_W;
    localparam int CNT_W      = lrp_pkg::CNT_W;
    localparam int FRAMES_DEF = lrp_pkg::FRAMES_DEF;
    localparam int CFG_RESET  = lrp_pkg::CFG_RESET;

    typedef struct packed {
        logic             hit;
        logic             victim_valid;
        logic [PW-1:0]    victim_page;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
    } replace_result_t;

    // index 0 holds the most recent page
    logic [PW-1:0]    recency_stack[$];
    replace_result_t  expected_results[$];
    logic [CFG_W-1:0] frame_limit;
    logic [CNT_W-1:0] hits_so_far;
    logic [CNT_W-1:0] misses_so_far;

    task automatic predict_reference(input logic [PW-1:0] pg);
        replace_result_t r;
        int              where;
        int unsigned     cap;
        r     = '0;
        where = -1;
        foreach (recency_stack[k])
            if (where < 0 && recency_stack[k] == pg)
                where = k;
        cap = 32'(frame_limit);
        if (cap == 0)
            cap = 1;
        if (cap > FRAMES_DEF)
            cap = FRAMES_DEF;
        if (where >= 0)
        begin
            r.hit = 1'b1;
            if (hits_so_far != '1)
                hits_so_far = hits_so_far + CNT_W'(1);
            recency_stack.delete(where);
            recency_stack.insert(0, pg);
        end
        else
        begin
            if (misses_so_far != '1)
                misses_so_far = misses_so_far + CNT_W'(1);
            // a full set (or one left above a lowered limit) drops its oldest page
            if (recency_stack.size() >= cap)
            begin
                r.victim_valid = 1'b1;
                r.victim_page  = recency_stack[recency_stack.size() - 1];
                recency_stack.delete(recency_stack.size() - 1);
            end
            recency_stack.insert(0, pg);
        end
        r.hit_total  = hits_so_far;
        r.miss_total = misses_so_far;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        replace_result_t want;
        if (!rst_n)
        begin
            recency_stack.delete();
            expected_results.delete();
            frame_limit   = CFG_W'(CFG_RESET);
            hits_so_far   = '0;
            misses_so_far = '0;
            pending       = 0;
            fail_count    = 0;
            hit_seen      = 0;
            victim_seen   = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result with nothing expected, expected none, actual hit=%0b",
                             $time, rsp.hit);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("hit", want.hit, rsp.hit);
                    check_field("victim_valid", want.victim_valid, rsp.victim_valid);
                    check_field("victim_page", want.victim_page, rsp.victim_page);
                    check_field("hit_total", want.hit_total, rsp.hit_total);
                    check_field("miss_total", want.miss_total, rsp.miss_total);
                    hit_seen    += want.hit;
                    victim_seen += want.victim_valid;
                end
            end
            if (cfg_we)
                frame_limit = cfg_wdata;
            if (req.valid && req.ready)
                predict_reference(req.page_number);
            pending = expected_results.size();
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the LRU page tracker: directed references around the frame
// limit corner cases, then randomized working sets under several limits with
// random idling on both channels and a long result-side stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int PW              = lrp_pkg::PAGE_BITS_DEF;
    localparam int CFG_W           = lrp_pkg::CFG_W;
    localparam int FRAMES_DEF      = lrp_pkg::FRAMES_DEF;
    localparam int PAGE_MAX        = (1 << PW) - 1;
    localparam int RSP_HOLD_CYCLES = 800;          // well past the chain depth
    localparam int CYCLE_LIMIT     = 200000;       // watchdog bound for the whole run

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lrp_req_if req_ch ();
    lrp_rsp_if rsp_ch ();

    int pending;
    int fail_count;
    int hit_seen;
    int victim_seen;

    int cycle_count    = 0;
    int refs_sent      = 0;
    int limits_written = 0;
    bit idle_on        = 1'b1;   // random idling on both channels
    bit hold_rsp       = 1'b0;   // asks the result side for one long stall

    lru_page_replacement_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    lru_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .pending     (pending),
        .fail_count  (fail_count),
        .hit_seen    (hit_seen),
        .victim_seen (victim_seen)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // watchdog, counts every cycle from time zero
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lru_page_replacement_top regression: fail");
            $finish;
        end
    end

    // result side: random ready, plus one long hold-off when asked
    initial
    begin : rsp_side
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                // freeze results long enough that the input side backs up too
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
            end
            rsp_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 36);
        end
    end

    // one reference transaction; entered and left at a falling edge
    task automatic send_page(input logic [PW-1:0] pg);
        while (idle_on && $urandom_range(0, 99) < 36)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= pg;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        refs_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write, only called with the block idle
    task automatic set_frame_limit(input logic [CFG_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limits_written++;
        @(negedge clk);
    endtask

    // random working set: mostly pages from a pool, some noise from the full range;
    // a sweep first walks the whole pool so a large set fills up and starts evicting
    task automatic run_phase(input int lim, input int pool_size, input int count,
                             input bit sweep, input bit stall_results);
        logic [PW-1:0] pool[$];
        logic [PW-1:0] pg;
        int            i;
        set_frame_limit(lim[CFG_W-1:0]);
        for (i = 0; i < pool_size; i++)
            pool.push_back(PW'($urandom_range(0, PAGE_MAX)));
        for (i = 0; i < count; i++)
        begin
            if (sweep && i < pool_size)
                pg = pool[i];
            else if ($urandom_range(0, 99) < 85)
                pg = pool[$urandom_range(0, pool_size - 1)];
            else
                pg = PW'($urandom_range(0, PAGE_MAX));
            if (stall_results && i == 60)
                hold_rsp = 1'b1;
            send_page(pg);
        end
        drain();
    endtask

    initial
    begin : stimulus
        int lim;
        int k;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.page_number = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset limit: field extremes, hits at the back and next to the front of the stack
        send_page(20'h00000);
        send_page(20'hFFFFF);
        send_page(20'h55555);
        send_page(20'hAAAAA);
        send_page(20'h00000);
        send_page(20'hAAAAA);
        send_page(20'hFFFFF);
        drain();

        // zero limit acts as one frame; four pages resident so the set sits above it
        set_frame_limit('0);
        send_page(20'h12345);
        send_page(20'h12345);
        send_page(20'h55555);
        drain();

        // limit above capacity clamps to the full set, no eviction
        set_frame_limit('1);
        send_page(20'h12345);
        send_page(20'h00001);
        drain();

        // lowered below occupancy: miss evicts one, occupancy holds
        set_frame_limit(CFG_W'(2));
        send_page(20'h80000);
        send_page(20'h80000);
        drain();

        set_frame_limit(CFG_W'(1));
        send_page(20'h7FFFF);
        drain();

        // fill the full set with a sweep, with a long result stall early on
        run_phase(1023, 540, 650, 1'b1, 1'b1);
        // single frame with a full resident set left over from the sweep
        run_phase(1, 3, 80, 1'b0, 1'b0);
        // no idling on either side for this stretch
        idle_on = 1'b0;
        run_phase(0, 2, 40, 1'b0, 1'b0);
        idle_on = 1'b1;
        run_phase(FRAMES_DEF, 60, 160, 1'b0, 1'b0);
        for (k = 0; k < 3; k++)
        begin
            lim = $urandom_range(2, 40);
            run_phase(lim, lim + $urandom_range(1, lim), 110, 1'b0, 1'b0);
        end
        run_phase(3, 6, 75, 1'b0, 1'b0);

        // let anything stray from the chain show up
        repeat (FRAMES_DEF + 16) @(negedge clk);

        $display("covered %0d references under %0d frame limit settings",
                 refs_sent, limits_written);
        $display("checked %0d hits and %0d evictions", hit_seen, victim_seen);
        if (fail_count == 0 && pending == 0)
            $display("lru_page_replacement_top regression: pass");
        else
            $display("lru_page_replacement_top regression: fail");
        $finish;
    end

endmodule
